@@ hdl/rtc3w_pkg.sv @@
// Types, constants and the command index table for the three-wire RTC command interface.
package rtc3w_pkg;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_CMD   = 2'd1,
    PH_PARAM = 2'd2
  } phase_e;

  localparam logic [3:0] CMD_UNKNOWN   = 4'd0;
  localparam logic [7:0] FIXED_MASK    = 8'hE0;
  localparam logic [7:0] FIXED_PATTERN = 8'h60;
  localparam logic [7:0] READ_MASK     = 8'h10;
  localparam logic [7:0] INDEX_MASK    = 8'h0F;
  localparam logic [7:0] DATA_CLR_MASK = 8'hFE;
  localparam logic [7:0] COUNT_MAX     = 8'hFF;

  localparam int unsigned PIN_DATA = 0;
  localparam int unsigned PIN_CLK  = 1;
  localparam int unsigned PIN_SEL  = 2;
  localparam int unsigned PIN_DIR  = 4;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  function automatic logic [3:0] cmd_of_index(input logic [3:0] idx);
    logic [3:0] cmd;
    unique case (idx)
      4'd0:    cmd = 4'd1;
      4'd1:    cmd = 4'd2;
      4'd2:    cmd = 4'd3;
      4'd3:    cmd = 4'd4;
      4'd4:    cmd = 4'd5;
      4'd5:    cmd = 4'd6;
      4'd6:    cmd = 4'd7;
      4'd7:    cmd = 4'd8;
      4'd10:   cmd = 4'd9;
      default: cmd = CMD_UNKNOWN;
    endcase
    return cmd;
  endfunction

endpackage

@@ hdl/rtc_three_wire_command_interface.sv @@
// Top level: pin-register front end of the three-wire RTC serial command interface.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid_i/in_ready_o | kind_i, pin_value_i
//  out     | output    | out_valid_o/out_ready_i | read_data_o, phase_o, command_o,
//          |           |                      | read_request_o, param_count_o, command_error_o
//
// One word per cycle: an accepted write word updates the pin state, and every word
// accepted at an edge loads the result register at that edge, so its result is valid
// the next cycle. The single result register sets the rate; a held result stalls input
// only when out_ready_i is low. Reset clears all pin and transfer state to idle.
module rtc_three_wire_command_interface (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       kind_i,
  input  logic [7:0] pin_value_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic [1:0] phase_o,
  output logic [3:0] command_o,
  output logic       read_request_o,
  output logic [7:0] param_count_o,
  output logic       command_error_o
);

  logic [7:0]           last_pins_q, last_pins_d;
  logic                 clk_high_q, clk_high_d;
  logic                 sel_high_q, sel_high_d;
  rtc3w_pkg::phase_e    phase_q, phase_d;
  logic [7:0]           shift_q, shift_d;
  logic [2:0]           bit_idx_q, bit_idx_d;
  logic [7:0]           param_q, param_d;
  logic [3:0]           cmd_q, cmd_d;
  logic                 rd_flag_q, rd_flag_d;
  logic                 err_d;
  logic [7:0]           readback_d;

  logic [7:0]           rd_data_q;
  logic [1:0]           phase_out_q;
  logic [3:0]           cmd_out_q;
  logic                 rd_req_q;
  logic [7:0]           param_out_q;
  logic                 err_q;
  logic                 out_valid_q;

  logic                 in_acc;
  logic                 sel, pclk, pdata, pdir;
  logic [7:0]           shifted;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  assign sel   = pin_value_i[rtc3w_pkg::PIN_SEL];
  assign pclk  = pin_value_i[rtc3w_pkg::PIN_CLK];
  assign pdata = pin_value_i[rtc3w_pkg::PIN_DATA];
  assign pdir  = pin_value_i[rtc3w_pkg::PIN_DIR];

  always_comb begin
    last_pins_d = last_pins_q;
    clk_high_d  = clk_high_q;
    sel_high_d  = sel_high_q;
    phase_d     = phase_q;
    shift_d     = shift_q;
    bit_idx_d   = bit_idx_q;
    param_d     = param_q;
    cmd_d       = cmd_q;
    rd_flag_d   = rd_flag_q;
    err_d       = 1'b0;
    shifted     = shift_q;
    if (phase_q == rtc3w_pkg::PH_CMD || pdir) begin
      shifted = shift_q | ({7'd0, pdata} << bit_idx_q);
    end
    if (in_acc && kind_i == rtc3w_pkg::KIND_WRITE) begin
      priority if (sel_high_q && !sel) begin
        phase_d   = rtc3w_pkg::PH_IDLE;
        bit_idx_d = 3'd0;
        shift_d   = 8'd0;
        param_d   = 8'd0;
        cmd_d     = rtc3w_pkg::CMD_UNKNOWN;
        rd_flag_d = 1'b0;
      end else if (!sel_high_q && sel) begin
        phase_d   = rtc3w_pkg::PH_CMD;
        bit_idx_d = 3'd0;
        shift_d   = 8'd0;
        param_d   = 8'd0;
        cmd_d     = rtc3w_pkg::CMD_UNKNOWN;
      end else if (sel && !clk_high_q && pclk && phase_q != rtc3w_pkg::PH_IDLE) begin
        if (bit_idx_q == 3'd7) begin
          bit_idx_d = 3'd0;
          shift_d   = 8'd0;
          if (phase_q == rtc3w_pkg::PH_CMD) begin
            if ((shifted & rtc3w_pkg::FIXED_MASK) != rtc3w_pkg::FIXED_PATTERN) begin
              cmd_d = rtc3w_pkg::CMD_UNKNOWN;
              err_d = 1'b1;
            end else begin
              rd_flag_d = (shifted & rtc3w_pkg::READ_MASK) != 8'd0;
              cmd_d     = rtc3w_pkg::cmd_of_index(shifted[3:0]);
              phase_d   = rtc3w_pkg::PH_PARAM;
              param_d   = 8'd0;
            end
          end else if (param_q != rtc3w_pkg::COUNT_MAX) begin
            param_d = param_q + 8'd1;
          end
        end else begin
          shift_d   = shifted;
          bit_idx_d = bit_idx_q + 3'd1;
        end
      end
      last_pins_d = pin_value_i;
      sel_high_d  = sel;
      clk_high_d  = pclk;
    end
    if (phase_d == rtc3w_pkg::PH_PARAM && rd_flag_d && cmd_d != rtc3w_pkg::CMD_UNKNOWN) begin
      readback_d = (last_pins_d & rtc3w_pkg::DATA_CLR_MASK) | {7'd0, shift_d[bit_idx_d]};
    end else begin
      readback_d = last_pins_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pins_q <= 8'd0;
      clk_high_q  <= 1'b0;
      sel_high_q  <= 1'b0;
      phase_q     <= rtc3w_pkg::PH_IDLE;
      shift_q     <= 8'd0;
      bit_idx_q   <= 3'd0;
      param_q     <= 8'd0;
      cmd_q       <= rtc3w_pkg::CMD_UNKNOWN;
      rd_flag_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      last_pins_q <= last_pins_d;
      clk_high_q  <= clk_high_d;
      sel_high_q  <= sel_high_d;
      phase_q     <= phase_d;
      shift_q     <= shift_d;
      bit_idx_q   <= bit_idx_d;
      param_q     <= param_d;
      cmd_q       <= cmd_d;
      rd_flag_q   <= rd_flag_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_data_q   <= readback_d;
      phase_out_q <= phase_d;
      cmd_out_q   <= cmd_d;
      rd_req_q    <= rd_flag_d;
      param_out_q <= param_d;
      err_q       <= err_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = rd_data_q;
  assign phase_o         = phase_out_q;
  assign command_o       = cmd_out_q;
  assign read_request_o  = rd_req_q;
  assign param_count_o   = param_out_q;
  assign command_error_o = err_q;

`ifndef SYNTH
  a_err_stays_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_error_o |->
      phase_o == rtc3w_pkg::PH_CMD && command_o == rtc3w_pkg::CMD_UNKNOWN)
    else $error("command error without command phase and unknown command");
  a_count_in_param: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && param_count_o != 8'd0 |-> phase_o == rtc3w_pkg::PH_PARAM)
    else $error("parameter count outside parameter phase");
  a_read_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && kind_i == rtc3w_pkg::KIND_READ |=>
      $stable(last_pins_q) && $stable(phase_q) && $stable(shift_q) && $stable(param_q))
    else $error("pin read changed transfer state");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !in_acc |=> !out_valid_o)
    else $error("result word repeated");
`endif

endmodule
